>>> rtl/sccc_pkg.sv
`timescale 1ns / 1ps
package sccc_pkg;

  localparam int SetCountDef  = 256;
  localparam int WayCountDef  = 4;
  localparam int LineBytesDef = 64;

  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_S  = 3'd1,
    ST_E  = 3'd2,
    ST_M  = 3'd3,
    ST_SC = 3'd4,
    ST_SM = 3'd5
  } line_state_e;

  typedef enum logic [2:0] {
    OP_RD     = 3'd0,
    OP_WR     = 3'd1,
    OP_BUSRD  = 3'd2,
    OP_BUSRDX = 3'd3,
    OP_BUSUPG = 3'd4,
    OP_BUSUPD = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_MSI    = 2'd0,
    MODE_MESI   = 2'd1,
    MODE_DRAGON = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_CLEAR,
    CTL_LOOKUP
  } ctl_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] address;
    logic        shared_elsewhere;
  } req_t;

  typedef struct packed {
    logic hit;
    logic issue_bus_read;
    logic issue_bus_read_excl;
    logic issue_bus_upgrade;
    logic issue_bus_update;
    logic victim_writeback;
    logic flush;
    logic intervention;
    logic invalidation;
    logic cache_to_cache;
    logic memory_transaction;
  } rsp_t;

endpackage

>>> rtl/sccc_tag_store.sv
`timescale 1ns / 1ps
module sccc_tag_store import sccc_pkg::*; #(
  parameter int SetCount = SetCountDef,
  parameter int WayCount = WayCountDef,
  parameter int IdxW     = (SetCount > 1) ? $clog2(SetCount) : 1,
  parameter int TagW     = 18,
  parameter int RankW    = (WayCount > 1) ? $clog2(WayCount) : 1
) (
  input  logic                          clk_i,
  input  logic [IdxW-1:0]               rd_idx_i,
  input  logic [IdxW-1:0]               wr_idx_i,
  input  logic                          wr_en_i,
  input  logic [WayCount-1:0][TagW-1:0] wr_tag_i,
  input  logic [WayCount-1:0][2:0]      wr_st_i,
  input  logic [WayCount-1:0][RankW-1:0] wr_rank_i,
  output logic [WayCount-1:0][TagW-1:0] rd_tag_o,
  output logic [WayCount-1:0][2:0]      rd_st_o,
  output logic [WayCount-1:0][RankW-1:0] rd_rank_o
);

  // one row per set, all ways side by side
  logic [WayCount-1:0][TagW-1:0]  tag_mem  [SetCount];
  logic [WayCount-1:0][2:0]       st_mem   [SetCount];
  logic [WayCount-1:0][RankW-1:0] rank_mem [SetCount];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_idx_i]  <= wr_tag_i;
      st_mem[wr_idx_i]   <= wr_st_i;
      rank_mem[wr_idx_i] <= wr_rank_i;
    end
    rd_tag_o  <= tag_mem[rd_idx_i];
    rd_st_o   <= st_mem[rd_idx_i];
    rd_rank_o <= rank_mem[rd_idx_i];
  end

endmodule

>>> rtl/sccc_protocol.sv
`timescale 1ns / 1ps
module sccc_protocol import sccc_pkg::*; #(
  parameter int WayCount = WayCountDef,
  parameter int TagW     = 18,
  parameter int RankW    = (WayCount > 1) ? $clog2(WayCount) : 1
) (
  input  req_t                           req_i,
  input  logic [TagW-1:0]                tag_i,
  input  logic [1:0]                     mode_i,
  input  logic [WayCount-1:0][TagW-1:0]  tag_rd_i,
  input  logic [WayCount-1:0][2:0]       st_rd_i,
  input  logic [WayCount-1:0][RankW-1:0] rank_rd_i,
  output logic [WayCount-1:0][TagW-1:0]  tag_wr_o,
  output logic [WayCount-1:0][2:0]       st_wr_o,
  output logic [WayCount-1:0][RankW-1:0] rank_wr_o,
  output rsp_t                           rsp_o
);

  localparam int WayW = (WayCount > 1) ? $clog2(WayCount) : 1;

  logic            present, any_inv, wr, sh, local_op;
  logic [WayW-1:0] hit_way, inv_way, lru_way, sel_way;
  logic [2:0]      st, nst;
  logic [1:0]      mode;
  logic [RankW-1:0] sel_rank;

  always_comb begin
    present = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int w = WayCount - 1; w >= 0; w--) begin
      if (st_rd_i[w] != ST_I && tag_rd_i[w] == tag_i) begin
        present = 1'b1;
        hit_way = WayW'(w);
      end
      if (st_rd_i[w] == ST_I) begin
        any_inv = 1'b1;
        inv_way = WayW'(w);
      end
    end
    for (int w = 1; w < WayCount; w++) begin
      if (rank_rd_i[w] > rank_rd_i[lru_way]) lru_way = WayW'(w);
    end
  end

  always_comb begin
    mode     = (mode_i == 2'd3) ? MODE_MSI : mode_i;
    wr       = req_i.operation == OP_WR;
    sh       = req_i.shared_elsewhere;
    local_op = req_i.operation == OP_RD || req_i.operation == OP_WR;
    sel_way  = present ? hit_way : (any_inv ? inv_way : lru_way);
    st       = st_rd_i[sel_way];
    sel_rank = rank_rd_i[sel_way];
    nst      = st;
    rsp_o    = '0;
    tag_wr_o = tag_rd_i;
    rank_wr_o = rank_rd_i;
    if (req_i.operation <= OP_BUSUPD) rsp_o.hit = present;
    if (local_op) begin
      // promote the touched way, age the more recent ones
      for (int w = 0; w < WayCount; w++) begin
        if (rank_rd_i[w] < sel_rank) rank_wr_o[w] = rank_rd_i[w] + RankW'(1);
      end
      rank_wr_o[sel_way] = '0;
    end
    if (local_op && !present) begin
      tag_wr_o[sel_way] = tag_i;
      rsp_o.victim_writeback = st == ST_M || st == ST_SM;
      unique case (mode)
        MODE_MESI: begin
          rsp_o.cache_to_cache     = sh;
          rsp_o.memory_transaction = !sh;
          if (wr) begin
            nst = ST_M; rsp_o.issue_bus_read_excl = 1'b1;
          end else begin
            nst = sh ? ST_S : ST_E; rsp_o.issue_bus_read = 1'b1;
          end
        end
        MODE_DRAGON: begin
          rsp_o.memory_transaction = 1'b1;
          rsp_o.issue_bus_read     = 1'b1;
          if (wr) begin
            nst = sh ? ST_SM : ST_M; rsp_o.issue_bus_update = sh;
          end else begin
            nst = sh ? ST_SC : ST_E;
          end
        end
        default: begin
          rsp_o.memory_transaction = 1'b1;
          if (wr) begin
            nst = ST_M; rsp_o.issue_bus_read_excl = 1'b1;
          end else begin
            nst = ST_S; rsp_o.issue_bus_read = 1'b1;
          end
        end
      endcase
    end else if (local_op) begin
      if (wr) begin
        unique case (mode)
          MODE_MESI: begin
            if (st == ST_S) begin
              rsp_o.issue_bus_upgrade = 1'b1; nst = ST_M;
            end else if (st == ST_E) nst = ST_M;
          end
          MODE_DRAGON: begin
            if (st == ST_E) nst = ST_M;
            else if (st == ST_SC) begin
              rsp_o.issue_bus_update = 1'b1; nst = sh ? ST_SM : ST_M;
            end else if (st == ST_SM) begin
              rsp_o.issue_bus_update = 1'b1; if (!sh) nst = ST_M;
            end
          end
          default: begin
            if (st == ST_S) begin
              rsp_o.issue_bus_read_excl = 1'b1;
              rsp_o.memory_transaction  = 1'b1;
              nst = ST_M;
            end
          end
        endcase
      end
    end else if (present) begin
      case (req_i.operation)
        OP_BUSRD: begin
          if (mode == MODE_DRAGON) begin
            if (st == ST_M) begin
              nst = ST_SM; rsp_o.intervention = 1'b1; rsp_o.flush = 1'b1;
            end else if (st == ST_E) begin
              nst = ST_SC; rsp_o.intervention = 1'b1;
            end else if (st == ST_SM) rsp_o.flush = 1'b1;
          end else if (st == ST_M) begin
            nst = ST_S;
            rsp_o.flush = 1'b1; rsp_o.memory_transaction = 1'b1;
            rsp_o.intervention = 1'b1;
          end else if (mode == MODE_MESI && st == ST_E) begin
            nst = ST_S; rsp_o.intervention = 1'b1;
          end
        end
        OP_BUSRDX: begin
          if (st == ST_M) begin
            rsp_o.flush = 1'b1; rsp_o.memory_transaction = 1'b1;
          end
          nst = ST_I;
          rsp_o.invalidation = 1'b1;
        end
        OP_BUSUPG: begin
          if (st == ST_S) begin
            nst = ST_I; rsp_o.invalidation = 1'b1;
          end
        end
        OP_BUSUPD: if (st == ST_SM) nst = ST_SC;
        default: ;
      endcase
    end
    st_wr_o = st_rd_i;
    st_wr_o[sel_way] = nst;
  end

endmodule

>>> rtl/snooping_coherent_cache_controller_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// request | in        | start_i & !busy_o      | req_i (req_t)
// result  | out       | rsp_valid_o (strobe)   | rsp_o (rsp_t)
// config  | in        | cfg_valid_i & cfg_ready_o | cfg_data_i (protocol mode)
// For each item the set is read from the tag memory at the accepting edge,
// then compared and written back at the next edge, as the tag memory read is
// registered. The result strobe follows in the cycle after that.
// After reset a clearing pass writes every set in turn (all ways invalid,
// ranks in way order) while busy_o stays high.
// Results cannot be stalled; rsp_valid_o is high for one cycle per item.
module snooping_coherent_cache_controller_core import sccc_pkg::*; #(
  parameter int SetCount  = SetCountDef,
  parameter int WayCount  = WayCountDef,
  parameter int LineBytes = LineBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  req_t       req_i,
  output logic       busy_o,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  localparam int OffW  = $clog2(LineBytes);
  localparam int IdxW  = (SetCount > 1) ? $clog2(SetCount) : 1;
  localparam int IdxB  = $clog2(SetCount);
  localparam int TagW  = 32 - OffW - IdxB;
  localparam int RankW = (WayCount > 1) ? $clog2(WayCount) : 1;
  localparam int CntW  = $clog2(SetCount + 1);

  ctl_e state_q, state_d;
  logic [CntW-1:0] clr_q, clr_d;
  req_t req_q;
  logic [1:0] mode_q;
  logic rsp_valid_q;
  rsp_t rsp_q;

  logic [IdxW-1:0] rd_idx, wr_idx, req_idx;
  logic [TagW-1:0] req_tag;
  logic wr_en;
  logic [WayCount-1:0][TagW-1:0]  tag_rd, tag_wr, tag_nx;
  logic [WayCount-1:0][2:0]       st_rd, st_wr, st_nx;
  logic [WayCount-1:0][RankW-1:0] rank_rd, rank_wr, rank_nx;
  rsp_t rsp_nx;

  logic [31:0] line_addr;
  logic [31:0] in_line;

  assign line_addr = req_q.address >> OffW;
  assign in_line   = req_i.address >> OffW;
  assign req_idx   = (SetCount > 1) ? IdxW'(line_addr) : '0;
  assign req_tag   = TagW'(line_addr >> IdxB);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      CTL_CLEAR: begin
        clr_d = clr_q + CntW'(1);
        if (clr_q == CntW'(SetCount - 1)) state_d = CTL_IDLE;
      end
      CTL_IDLE:   if (start_i) state_d = CTL_LOOKUP;
      CTL_LOOKUP: state_d = CTL_IDLE;
      default:    state_d = CTL_IDLE;
    endcase
  end

  always_comb begin
    busy_o  = state_q != CTL_IDLE;
    wr_en   = 1'b0;
    wr_idx  = req_idx;
    rd_idx  = (SetCount > 1) ? IdxW'(in_line) : '0;
    tag_wr  = tag_nx;
    st_wr   = st_nx;
    rank_wr = rank_nx;
    unique case (state_q)
      CTL_CLEAR: begin
        wr_en  = 1'b1;
        wr_idx = IdxW'(clr_q);
        tag_wr = '0;
        st_wr  = '0;
        for (int w = 0; w < WayCount; w++) rank_wr[w] = RankW'(w);
      end
      CTL_LOOKUP: wr_en = 1'b1;
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_CLEAR;
      clr_q       <= '0;
      mode_q      <= MODE_MSI;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= state_q == CTL_LOOKUP;
      if (cfg_valid_i) mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CTL_IDLE && start_i) req_q <= req_i;
    if (state_q == CTL_LOOKUP) rsp_q <= rsp_nx;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  sccc_tag_store #(
    .SetCount(SetCount), .WayCount(WayCount), .IdxW(IdxW), .TagW(TagW), .RankW(RankW)
  ) u_store (
    .clk_i, .rd_idx_i(rd_idx), .wr_idx_i(wr_idx), .wr_en_i(wr_en),
    .wr_tag_i(tag_wr), .wr_st_i(st_wr), .wr_rank_i(rank_wr),
    .rd_tag_o(tag_rd), .rd_st_o(st_rd), .rd_rank_o(rank_rd)
  );

  sccc_protocol #(
    .WayCount(WayCount), .TagW(TagW), .RankW(RankW)
  ) u_proto (
    .req_i(req_q), .tag_i(req_tag), .mode_i(mode_q),
    .tag_rd_i(tag_rd), .st_rd_i(st_rd), .rank_rd_i(rank_rd),
    .tag_wr_o(tag_nx), .st_wr_o(st_nx), .rank_wr_o(rank_nx), .rsp_o(rsp_nx)
  );

`ifndef ASSERT_OFF
  a_strobe_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q == CTL_LOOKUP)) else $error("stray result");
  a_lookup_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_IDLE && start_i) |=> state_q == CTL_LOOKUP) else $error("lost item");
  a_busy_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CTL_LOOKUP |-> busy_o) else $error("not busy");
`endif

endmodule

>>> bench/snooping_coherent_cache_controller_core_tb.sv
`timescale 1ns / 1ps
module snooping_coherent_cache_controller_core_tb;
  import sccc_pkg::*;

  localparam int Sets = 256;
  localparam int Ways = 4;
  localparam int WatchdogLimit = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  req_t       req_i = '0;
  logic       busy_o;
  logic       rsp_valid_o;
  rsp_t       rsp_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i = '0;

  snooping_coherent_cache_controller_core i_dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .rsp_valid_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  logic [1:0]  coh_mode;
  logic [17:0] tag_mem [Sets][Ways];
  line_state_e state_mem [Sets][Ways];
  int unsigned rank_mem [Sets][Ways];

  req_t pending_items[$];
  rsp_t expected_rsps[$];
  int   send_idle_pct;
  int   errors;
  int   quiet_cycles;
  logic [1:0] cfg_pending_data;
  logic       cfg_pending;

  function automatic void touch_way(int s, int w);
    int r;
    r = rank_mem[s][w];
    for (int k = 0; k < Ways; k++) if (rank_mem[s][k] < r) rank_mem[s][k]++;
    rank_mem[s][w] = 0;
  endfunction

  function automatic rsp_t predict_coherence(req_t it);
    rsp_t        o;
    int          s, w, v;
    logic [17:0] tg;
    logic        wr, sh;
    line_state_e st;
    o = '0;
    s = it.address[13:6];
    tg = it.address[31:14];
    sh = it.shared_elsewhere;
    w = Ways;
    for (int k = Ways - 1; k >= 0; k--)
      if (state_mem[s][k] != ST_I && tag_mem[s][k] == tg) w = k;
    if (it.operation > OP_BUSUPD) return o;
    o.hit = (w < Ways);
    if (it.operation == OP_RD || it.operation == OP_WR) begin
      wr = (it.operation == OP_WR);
      if (w == Ways) begin
        v = Ways;
        for (int k = Ways - 1; k >= 0; k--) if (state_mem[s][k] == ST_I) v = k;
        if (v == Ways) begin
          v = 0;
          for (int k = 1; k < Ways; k++) if (rank_mem[s][k] > rank_mem[s][v]) v = k;
        end
        o.victim_writeback = (state_mem[s][v] == ST_M || state_mem[s][v] == ST_SM);
        tag_mem[s][v] = tg;
        touch_way(s, v);
        if (coh_mode == MODE_MESI) begin
          if (sh) o.cache_to_cache = 1'b1; else o.memory_transaction = 1'b1;
          if (wr) begin
            st = ST_M; o.issue_bus_read_excl = 1'b1;
          end else begin
            st = sh ? ST_S : ST_E; o.issue_bus_read = 1'b1;
          end
        end else if (coh_mode == MODE_DRAGON) begin
          o.memory_transaction = 1'b1;
          o.issue_bus_read = 1'b1;
          if (wr) begin
            st = sh ? ST_SM : ST_M; o.issue_bus_update = sh;
          end else begin
            st = sh ? ST_SC : ST_E;
          end
        end else begin
          o.memory_transaction = 1'b1;
          st = wr ? ST_M : ST_S;
          o.issue_bus_read_excl = wr;
          o.issue_bus_read = !wr;
        end
        state_mem[s][v] = st;
      end else begin
        touch_way(s, w);
        st = state_mem[s][w];
        if (wr) begin
          if (coh_mode == MODE_MESI) begin
            if (st == ST_S) begin
              o.issue_bus_upgrade = 1'b1; st = ST_M;
            end else if (st == ST_E) st = ST_M;
          end else if (coh_mode == MODE_DRAGON) begin
            if (st == ST_E) st = ST_M;
            else if (st == ST_SC) begin
              o.issue_bus_update = 1'b1; st = sh ? ST_SM : ST_M;
            end else if (st == ST_SM) begin
              o.issue_bus_update = 1'b1; if (!sh) st = ST_M;
            end
          end else if (st == ST_S) begin
            o.issue_bus_read_excl = 1'b1; o.memory_transaction = 1'b1; st = ST_M;
          end
        end
        state_mem[s][w] = st;
      end
      return o;
    end
    if (w == Ways) return o;
    st = state_mem[s][w];
    case (it.operation)
      OP_BUSRD: begin
        if (coh_mode == MODE_DRAGON) begin
          if (st == ST_M) begin
            st = ST_SM; o.intervention = 1'b1; o.flush = 1'b1;
          end else if (st == ST_E) begin
            st = ST_SC; o.intervention = 1'b1;
          end else if (st == ST_SM) o.flush = 1'b1;
        end else if (st == ST_M) begin
          st = ST_S; o.flush = 1'b1; o.memory_transaction = 1'b1; o.intervention = 1'b1;
        end else if (coh_mode == MODE_MESI && st == ST_E) begin
          st = ST_S; o.intervention = 1'b1;
        end
      end
      OP_BUSRDX: begin
        if (st == ST_M) begin
          o.flush = 1'b1; o.memory_transaction = 1'b1;
        end
        st = ST_I;
        o.invalidation = 1'b1;
      end
      OP_BUSUPG: begin
        if (st == ST_S) begin
          st = ST_I; o.invalidation = 1'b1;
        end
      end
      default: if (st == ST_SM) st = ST_SC;
    endcase
    state_mem[s][w] = st;
    return o;
  endfunction

  logic item_taken;
  always @(posedge clk_i) begin
    item_taken <= start_i && !busy_o && rst_ni;
    if (rst_ni && start_i && !busy_o) begin
      expected_rsps.push_back(predict_coherence(req_i));
      quiet_cycles <= 0;
    end else if (rst_ni && rsp_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) coh_mode = cfg_data_i;
    if (rst_ni && rsp_valid_o) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %b", $time, rsp_o);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (e !== rsp_o) begin
          $display("%0t: result mismatch expected %b actual %b", $time, e, rsp_o);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      // drop the item accepted at the last rising edge
      if (item_taken) void'(pending_items.pop_front());
      if (cfg_valid_i && cfg_ready_o) cfg_valid_i <= 1'b0;
      else if (cfg_pending && !cfg_valid_i) begin
        cfg_valid_i <= 1'b1;
        cfg_data_i  <= cfg_pending_data;
        cfg_pending <= 1'b0;
      end
      if (pending_items.size() != 0 &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        start_i <= 1'b1;
        req_i   <= pending_items[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  initial begin
    errors = 0;
    quiet_cycles = 0;
    cfg_pending = 1'b0;
    coh_mode = MODE_MSI;
    send_idle_pct = 26;
    for (int s = 0; s < Sets; s++)
      for (int w = 0; w < Ways; w++) begin
        state_mem[s][w] = ST_I;
        rank_mem[s][w] = w;
        tag_mem[s][w] = '0;
      end
  end

  function automatic req_t make_item(logic [2:0] op, logic [31:0] a, logic sh);
    req_t r;
    r.operation = op;
    r.address = a;
    r.shared_elsewhere = sh;
    return r;
  endfunction

  // Addresses from a small pool of sets and tags so lines get reused
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(9, 0) != 0) begin
      a[13:6]  = 8'($urandom_range(3, 0) * 85);
      a[31:14] = {$urandom_range(1, 0) ? 18'h3ffff : 18'h0} ^ 18'($urandom_range(5, 0));
    end
    return a;
  endfunction

  task automatic drain_and_set_mode(logic [1:0] m);
    while (pending_items.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    cfg_pending_data = m;
    cfg_pending = 1'b1;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(9, 0) < 6) ? 3'($urandom_range(1, 0))
           : 3'($urandom_range(7, 2));
      pending_items.push_back(make_item(op, pick_address(), 1'($urandom)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed: extremes, each op, eviction with dirty victim, unused codes
    drain_and_set_mode(MODE_MESI);
    pending_items.push_back(make_item(OP_RD, 32'h0, 1'b0));
    pending_items.push_back(make_item(OP_WR, 32'h0, 1'b0));
    pending_items.push_back(make_item(OP_BUSRD, 32'h0, 1'b0));
    pending_items.push_back(make_item(OP_WR, 32'h0, 1'b1));
    pending_items.push_back(make_item(OP_BUSRDX, 32'h0, 1'b0));
    pending_items.push_back(make_item(OP_RD, 32'hffff_ffff, 1'b1));
    pending_items.push_back(make_item(OP_BUSUPG, 32'hffff_ffff, 1'b1));
    for (int t = 0; t < 5; t++)
      pending_items.push_back(make_item(OP_WR, {18'(t + 1), 8'h55, 6'h3f}, 1'b0));
    pending_items.push_back(make_item(3'd6, 32'h0, 1'b1));
    pending_items.push_back(make_item(3'd7, 32'hffff_ffff, 1'b0));
    drain_and_set_mode(MODE_DRAGON);
    pending_items.push_back(make_item(OP_WR, {18'd2, 8'h55, 6'h0}, 1'b1));
    pending_items.push_back(make_item(OP_BUSUPD, {18'd2, 8'h55, 6'h0}, 1'b0));
    pending_items.push_back(make_item(OP_WR, {18'd2, 8'h55, 6'h0}, 1'b1));
    pending_items.push_back(make_item(OP_BUSRD, {18'd2, 8'h55, 6'h0}, 1'b0));
    pending_items.push_back(make_item(OP_RD, {18'd9, 8'h0, 6'h0}, 1'b0));
    pending_items.push_back(make_item(OP_BUSRD, {18'd9, 8'h0, 6'h0}, 1'b0));
    pending_items.push_back(make_item(OP_WR, {18'd9, 8'h0, 6'h0}, 1'b0));
    drain_and_set_mode(2'd3);
    pending_items.push_back(make_item(OP_WR, {18'd9, 8'h0, 6'h0}, 1'b0));
    pending_items.push_back(make_item(OP_BUSRD, {18'd2, 8'h55, 6'h0}, 1'b0));
    // Random phases across modes and idling profiles
    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 26 : (ph < 6) ? 70 : 0;
      drain_and_set_mode(2'(ph % 4 == 3 ? 3 : ph % 3));
      queue_random(92);
    end
    while (pending_items.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Covers the clearing pass after reset and the longest sender gaps
  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
